[hw/rtl/lflt_pkg.sv]
// Package for the login failure lockout table.
// Holds sizes, operation and status codes, register indexes and the beat type
// that travels along the row of table cells. No dependencies.
package lflt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = IDX_BITS + 1;
  localparam int COUNT_BITS  = 16;
  localparam int LIMIT_BITS  = 16;
  localparam int LOCKOUT_BITS = 31;
  localparam int KEY_BITS    = 64;
  localparam int TIME_BITS   = 64;
  localparam int CFG_DATA_BITS = 31;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [LIMIT_BITS-1:0]   LIMIT_RESET   = 16'd5;
  localparam logic [LOCKOUT_BITS-1:0] LOCKOUT_RESET = 31'd300000;

  localparam logic [CFG_IDX_BITS-1:0] REG_FAILURE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT_TIME  = 1'd1;

  localparam logic [1:0] FUNC_RECORD = 2'd0;
  localparam logic [1:0] FUNC_CHECK  = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_LOCKED = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic                  inserted;
    logic [1:0]            func;
    logic [KEY_BITS-1:0]   user_key;
    logic                  attempt_ok;
    logic [TIME_BITS-1:0]  now_time;
    logic [1:0]            status;
    logic                  lock_state;
    logic [COUNT_BITS-1:0] failure_count;
    logic                  user_found;
  } beat_t;

endpackage

[hw/rtl/lflt_if.sv]
// Valid/ready channel interfaces for the lockout table's input and result beats.
// Depends on lflt_pkg.
interface lflt_in_if;
  import lflt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            func;
  logic [KEY_BITS-1:0]   user_key;
  logic                  attempt_ok;
  logic [TIME_BITS-1:0]  now_time;

  modport source (output valid, input ready, output func, user_key, attempt_ok, now_time);
  modport sink   (input valid, output ready, input func, user_key, attempt_ok, now_time);
endinterface

interface lflt_out_if;
  import lflt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic                  lock_state;
  logic [COUNT_BITS-1:0] failure_count;
  logic                  user_found;

  modport source (output valid, input ready, output status, lock_state, failure_count,
                  user_found);
  modport sink   (input valid, output ready, input status, lock_state, failure_count,
                  user_found);
endinterface

[hw/rtl/login_failure_lockout_table.sv]
// Login failure lockout table: a row of 64 cells, one entry each; a beat walks
// one cell per cycle unless the output stalls, via the entry register, the cell
// registers and the output register. One item is in the row at a time; a new one
// is taken once the last has left. Reset empties the table and loads failure_limit
// 5 and lockout_time 300000. Depends on lflt_pkg, lflt_if, lflt_cell.
module login_failure_lockout_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lflt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lflt_pkg::CFG_DATA_BITS-1:0] cfg_data,
  lflt_in_if.sink                            in_ch,
  lflt_out_if.source                         out_ch
);
  import lflt_pkg::*;

  logic [LIMIT_BITS-1:0]   failure_limit;
  logic [LOCKOUT_BITS-1:0] lockout_time;
  logic [CNT_BITS-1:0]     entry_count;
  logic                    busy;
  logic                    adv;
  logic                    accept;
  logic                    out_valid;
  beat_t                   row [TABLE_DEPTH+1];
  beat_t                   head;
  beat_t                   tail;

  assign tail   = row[TABLE_DEPTH];
  assign adv    = !(tail.valid && out_valid && !out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !busy;

  always_comb begin
    head               = '0;
    head.valid         = 1'b1;
    head.func          = in_ch.func;
    head.user_key      = in_ch.user_key;
    head.attempt_ok    = in_ch.attempt_ok;
    head.now_time      = in_ch.now_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_limit <= LIMIT_RESET;
      lockout_time  <= LOCKOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FAILURE_LIMIT: failure_limit <= cfg_data[LIMIT_BITS-1:0];
        REG_LOCKOUT_TIME:  lockout_time  <= cfg_data[LOCKOUT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row[0].valid <= 1'b0;
    end else if (accept) begin
      row[0].valid <= 1'b1;
    end else if (adv) begin
      row[0].valid <= 1'b0;
    end
    if (accept) begin
      row[0].done          <= head.done;
      row[0].inserted      <= head.inserted;
      row[0].func          <= head.func;
      row[0].user_key      <= head.user_key;
      row[0].attempt_ok    <= head.attempt_ok;
      row[0].now_time      <= head.now_time;
      row[0].status        <= head.status;
      row[0].lock_state    <= head.lock_state;
      row[0].failure_count <= head.failure_count;
      row[0].user_found    <= head.user_found;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lflt_cell u_cell (
      .clk           (clk),
      .rst           (rst),
      .adv           (adv),
      .cell_idx      (IDX_BITS'(i)),
      .entry_count   (entry_count),
      .failure_limit (failure_limit),
      .lockout_time  (lockout_time),
      .beat_in       (row[i]),
      .beat_out      (row[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (adv && tail.valid) begin
        busy <= 1'b0;
      end
      if (adv && tail.valid) begin
        out_valid <= 1'b1;
        if (tail.inserted) begin
          entry_count <= entry_count + 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tail.valid) begin
      out_ch.lock_state    <= tail.lock_state;
      out_ch.failure_count <= tail.failure_count;
      out_ch.user_found    <= tail.user_found;
      if (tail.func == FUNC_RECORD && !tail.done) begin
        out_ch.status <= STATUS_FULL;
      end else begin
        out_ch.status <= tail.status;
      end
    end
  end

  assign out_ch.valid = out_valid;

endmodule

[hw/rtl/lflt_cell.sv]
// One table cell: holds one entry and processes the beat passing through it.
// Depends on lflt_pkg.
module lflt_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic [lflt_pkg::IDX_BITS-1:0]     cell_idx,
  input  logic [lflt_pkg::CNT_BITS-1:0]     entry_count,
  input  logic [lflt_pkg::LIMIT_BITS-1:0]   failure_limit,
  input  logic [lflt_pkg::LOCKOUT_BITS-1:0] lockout_time,
  input  lflt_pkg::beat_t                   beat_in,
  output lflt_pkg::beat_t                   beat_out
);
  import lflt_pkg::*;

  logic [KEY_BITS-1:0]   key;
  logic [COUNT_BITS-1:0] count;
  logic [TIME_BITS-1:0]  last_time;
  logic                  lock;

  logic [COUNT_BITS-1:0] count_next;
  logic [TIME_BITS-1:0]  last_time_next;
  logic                  lock_next;
  logic                  hit;
  logic                  ins;
  logic                  occupied;
  logic [COUNT_BITS-1:0] cur_count;
  logic [TIME_BITS-1:0]  cur_time;
  logic                  cur_lock;
  logic [COUNT_BITS-1:0] inc_count;
  logic [TIME_BITS-1:0]  elapsed;
  beat_t                 beat_next;

  assign occupied = {1'b0, cell_idx} < entry_count;
  assign hit = beat_in.valid && !beat_in.done && occupied && (key == beat_in.user_key);
  assign ins = beat_in.valid && !beat_in.done && (beat_in.func == FUNC_RECORD) &&
               ({1'b0, cell_idx} == entry_count);

  assign cur_count = ins ? '0 : count;
  assign cur_time  = ins ? '0 : last_time;
  assign cur_lock  = ins ? 1'b0 : lock;
  assign inc_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
  assign elapsed   = beat_in.now_time - cur_time;

  always_comb begin
    count_next     = cur_count;
    last_time_next = cur_time;
    lock_next      = cur_lock;
    beat_next      = beat_in;
    if (hit || ins) begin
      beat_next.done     = 1'b1;
      beat_next.inserted = ins;
      case (beat_in.func)
        FUNC_RECORD: begin
          beat_next.user_found = hit;
          if (beat_in.attempt_ok) begin
            count_next = '0;
            lock_next  = 1'b0;
          end else begin
            count_next     = inc_count;
            last_time_next = beat_in.now_time;
            if (inc_count >= failure_limit) begin
              lock_next        = 1'b1;
              beat_next.status = STATUS_LOCKED;
            end
          end
          beat_next.lock_state    = lock_next;
          beat_next.failure_count = count_next;
        end
        FUNC_CHECK: begin
          beat_next.user_found = 1'b1;
          if (cur_lock && (elapsed > {{(TIME_BITS-LOCKOUT_BITS){1'b0}}, lockout_time})) begin
            lock_next  = 1'b0;
            count_next = '0;
          end
          beat_next.lock_state    = lock_next;
          beat_next.failure_count = count_next;
        end
        FUNC_QUERY: begin
          beat_next.user_found    = 1'b1;
          beat_next.lock_state    = cur_lock;
          beat_next.failure_count = cur_count;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv && (hit || ins)) begin
      if (ins) begin
        key <= beat_in.user_key;
      end
      count     <= count_next;
      last_time <= last_time_next;
      lock      <= lock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (adv) begin
      beat_out.valid <= beat_next.valid;
    end
    if (adv) begin
      beat_out.done          <= beat_next.done;
      beat_out.inserted      <= beat_next.inserted;
      beat_out.func          <= beat_next.func;
      beat_out.user_key      <= beat_next.user_key;
      beat_out.attempt_ok    <= beat_next.attempt_ok;
      beat_out.now_time      <= beat_next.now_time;
      beat_out.status        <= beat_next.status;
      beat_out.lock_state    <= beat_next.lock_state;
      beat_out.failure_count <= beat_next.failure_count;
      beat_out.user_found    <= beat_next.user_found;
    end
  end

endmodule
